[src/drying_onset_time_solver_top_assert.svh]
// Assertion macros used by the drying onset time solver top level.
`ifndef DRYING_ONSET_TIME_SOLVER_TOP_ASSERT_SVH
`define DRYING_ONSET_TIME_SOLVER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DOTS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("dots: implication check failed");
`define DOTS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("dots: next-cycle check failed");
`else
`define DOTS_ASSERT_IMP(lbl, ante, cons)
`define DOTS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[src/dots_pkg.sv]
// Constants shared by the drying onset time solver modules.
package dots_pkg;
	localparam int BIOT_W  = 24;
	localparam int THETA_W = 16;
	localparam int TIME_W  = 32;
	localparam int XBITS   = 31;
	localparam int P2BITS  = 24;
	localparam int RBITS   = 48;
	localparam int SEARCH_STEPS_DEF = 15;
	localparam int FRAC_BITS_DEF    = 16;
	localparam logic [30:0] QA =
		31'((64'd7478556 * 64'd2147483648 + 64'd5000000) / 64'd10000000);
	localparam logic [30:0] QB =
		31'((64'd4653628 * 64'd2147483648 + 64'd5000000) / 64'd10000000);
	localparam logic [30:0] QC =
		31'((64'd1282064 * 64'd2147483648 + 64'd5000000) / 64'd10000000);
	localparam logic [23:0] QP2 =
		24'((64'd94094 * 64'd16777216 + 64'd50000) / 64'd100000);
endpackage

[src/dots_search.sv]
// Unrolled bisection of the cubic, three register stages per search step.
module dots_search #(
	parameter int SEARCH_STEPS = 15
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic [15:0] in_theta,
	input  logic [23:0] in_biot,
	output logic        out_valid,
	output logic [30:0] out_xm,
	output logic [23:0] out_biot
);
	import dots_pkg::*;

	logic        v_s[SEARCH_STEPS+1];
	logic [31:0] lo_s[SEARCH_STEPS+1];
	logic [31:0] hi_s[SEARCH_STEPS+1];
	logic [15:0] th_s[SEARCH_STEPS+1];
	logic [23:0] bi_s[SEARCH_STEPS+1];
	logic [30:0] xm_s[SEARCH_STEPS+1];

	assign v_s[0]  = in_valid;
	assign lo_s[0] = 32'd0;
	assign hi_s[0] = 32'h8000_0000;
	assign th_s[0] = in_theta;
	assign bi_s[0] = in_biot;
	assign xm_s[0] = 31'd0;

	for (genvar j = 0; j < SEARCH_STEPS; j++) begin : g_step
		logic [31:0] sum;
		logic [30:0] h;
		logic [61:0] hh;
		logic        v_s1, v_s2, v_s3;
		logic [30:0] h_s1, h2_s1, h_s2, h_s3;
		logic [31:0] lo_s1, hi_s1, lo_s2, hi_s2, lo_s3, hi_s3;
		logic [15:0] th_s1, th_s2, th_s3;
		logic [23:0] bi_s1, bi_s2, bi_s3;
		logic [61:0] p3, pb, pc;
		logic [31:0] g, g_s2;
		logic [62:0] pa;
		logic [31:0] lhs, rhs;
		logic        neg;

		assign sum = lo_s[j] + hi_s[j];
		assign h   = sum[31:1];
		assign hh  = h * h;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s1 <= 1'b0;
			end else if (en) begin
				v_s1 <= v_s[j];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				h_s1  <= h;
				h2_s1 <= hh[61:31];
				lo_s1 <= lo_s[j];
				hi_s1 <= hi_s[j];
				th_s1 <= th_s[j];
				bi_s1 <= bi_s[j];
			end
		end

		assign p3 = h2_s1 * h_s1;
		assign pb = QB * h_s1;
		assign pc = QC * h2_s1;
		assign g  = {1'b0, pb[61:31]} + {1'b0, p3[61:31]} - {1'b0, pc[61:31]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s2 <= 1'b0;
			end else if (en) begin
				v_s2 <= v_s1;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				g_s2  <= g;
				h_s2  <= h_s1;
				lo_s2 <= lo_s1;
				hi_s2 <= hi_s1;
				th_s2 <= th_s1;
				bi_s2 <= bi_s1;
			end
		end

		assign pa  = g_s2 * QA;
		assign lhs = pa[62:31];
		assign rhs = {17'h10000 - {1'b0, th_s2}, 15'd0};
		assign neg = lhs < rhs;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s3 <= 1'b0;
			end else if (en) begin
				v_s3 <= v_s2;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				lo_s3 <= neg ? {1'b0, h_s2} : lo_s2;
				hi_s3 <= neg ? hi_s2 : {1'b0, h_s2};
				h_s3  <= h_s2;
				th_s3 <= th_s2;
				bi_s3 <= bi_s2;
			end
		end

		assign v_s[j+1]  = v_s3;
		assign lo_s[j+1] = lo_s3;
		assign hi_s[j+1] = hi_s3;
		assign th_s[j+1] = th_s3;
		assign bi_s[j+1] = bi_s3;
		assign xm_s[j+1] = h_s3;
	end

	assign out_valid = v_s[SEARCH_STEPS];
	assign out_xm    = xm_s[SEARCH_STEPS];
	assign out_biot  = bi_s[SEARCH_STEPS];
endmodule

[src/dots_recip.sv]
// Pipelined restoring division giving 1/xm - 1 in Q32, one quotient bit per stage.
module dots_recip #(
	parameter int SEARCH_STEPS = 15,
	parameter int QW = 32 + SEARCH_STEPS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [30:0]   in_xm,
	input  logic [23:0]   in_biot,
	output logic          out_valid,
	output logic [QW-1:0] out_x,
	output logic [23:0]   out_biot
);
	logic          v_s[QW+1];
	logic [30:0]   rem_s[QW+1];
	logic [QW-1:0] q_s[QW+1];
	logic [31:0]   num_s[QW+1];
	logic [30:0]   d_s[QW+1];
	logic [23:0]   bi_s[QW+1];
	logic [31:0]   num0;

	assign num0     = 32'h8000_0000 - {1'b0, in_xm};
	assign v_s[0]   = in_valid;
	assign rem_s[0] = 31'(num0 >> SEARCH_STEPS);
	assign q_s[0]   = '0;
	assign num_s[0] = num0;
	assign d_s[0]   = in_xm;
	assign bi_s[0]  = in_biot;

	for (genvar k = 0; k < QW; k++) begin : g_bit
		localparam int I = QW - 1 - k;
		logic        b;
		logic [31:0] trial;
		logic [31:0] diff;
		logic        ge;

		if (I >= 32) begin : g_num
			assign b = num_s[k][I-32];
		end else begin : g_zero
			assign b = 1'b0;
		end

		assign trial = {rem_s[k], b};
		assign ge    = trial >= {1'b0, d_s[k]};
		assign diff  = trial - {1'b0, d_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? diff[30:0] : trial[30:0];
				q_s[k+1]   <= {q_s[k][QW-2:0], ge};
				num_s[k+1] <= num_s[k];
				d_s[k+1]   <= d_s[k];
				bi_s[k+1]  <= bi_s[k];
			end
		end
	end

	assign out_valid = v_s[QW];
	assign out_x     = q_s[QW];
	assign out_biot  = bi_s[QW];
endmodule

[src/dots_quot.sv]
// Scales the ratio by the Biot term: R = X * 2^(FRAC_BITS+24) / K over 48 stages.
module dots_quot #(
	parameter int FRAC_BITS = 16,
	parameter int XW = 47
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [XW-1:0] in_x,
	input  logic [23:0]   in_biot,
	output logic          out_valid,
	output logic [47:0]   out_r,
	output logic          out_ovf
);
	import dots_pkg::*;

	logic          v_a;
	logic [47:0]   k_a;
	logic [XW-1:0] x_a;
	logic [XW-1:0] r0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_a <= 1'b0;
		end else if (en) begin
			v_a <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			k_a <= in_biot * QP2;
			x_a <= in_x;
		end
	end

	assign r0 = x_a >> (P2BITS - FRAC_BITS);

	logic          v_s[RBITS+1];
	logic [47:0]   rem_s[RBITS+1];
	logic [47:0]   q_s[RBITS+1];
	logic          ovf_s[RBITS+1];
	logic [47:0]   k_s[RBITS+1];
	logic [XW-1:0] x_s[RBITS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= v_a;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s[0] <= 64'(r0) >= 64'(k_a);
			rem_s[0] <= 48'(r0);
			q_s[0]   <= '0;
			k_s[0]   <= k_a;
			x_s[0]   <= x_a;
		end
	end

	for (genvar k = 0; k < RBITS; k++) begin : g_bit
		localparam int I = RBITS - 1 - k;
		logic        b;
		logic [48:0] trial;
		logic [48:0] diff;
		logic        ge;

		if (I >= FRAC_BITS + P2BITS) begin : g_num
			assign b = x_s[k][I-FRAC_BITS-P2BITS];
		end else begin : g_zero
			assign b = 1'b0;
		end

		assign trial = {rem_s[k], b};
		assign ge    = trial >= {1'b0, k_s[k]};
		assign diff  = trial - {1'b0, k_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? diff[47:0] : trial[47:0];
				q_s[k+1]   <= {q_s[k][46:0], ge};
				ovf_s[k+1] <= ovf_s[k];
				k_s[k+1]   <= k_s[k];
				x_s[k+1]   <= x_s[k];
			end
		end
	end

	assign out_valid = v_s[RBITS];
	assign out_r     = q_s[RBITS];
	assign out_ovf   = ovf_s[RBITS];
endmodule

[src/dots_square.sv]
// Squares R from partial products, rescales and saturates into the output register.
module dots_square #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic [47:0] in_r,
	input  logic        in_ovf,
	output logic        out_valid,
	output logic [31:0] out_time,
	output logic        out_sat
);
	logic        v_s1, v_s2, v_s3;
	logic [63:0] ll_s1;
	logic [47:0] hl_s1;
	logic [31:0] hh_s1;
	logic        ovf_s1, ovf_s2;
	logic [95:0] sq_s2;
	logic        sat;
	logic [31:0] time_s3;
	logic        sat_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign sat = ovf_s2 | (|sq_s2[95:96-FRAC_BITS]);

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1   <= in_r[31:0] * in_r[31:0];
			hl_s1   <= in_r[47:32] * in_r[31:0];
			hh_s1   <= in_r[47:32] * in_r[47:32];
			ovf_s1  <= in_ovf;
			sq_s2   <= 96'(ll_s1) + (96'(hl_s1) << 33) + (96'(hh_s1) << 64);
			ovf_s2  <= ovf_s1;
			time_s3 <= sat ? 32'hFFFF_FFFF : sq_s2[95-FRAC_BITS:64-FRAC_BITS];
			sat_s3  <= sat;
		end
	end

	assign out_valid = v_s3;
	assign out_time  = time_s3;
	assign out_sat   = sat_s3;
endmodule

[src/drying_onset_time_solver_top.sv]
// Top level of the drying onset time solver pipeline.
// The block takes one item per clock while the output is not stalled and returns one item per input.
// The pipeline is made of three stages for each bisection step, 32+SEARCH_STEPS one-bit stages
// of the reciprocal divider, 50 stages for the Biot product and the 48-bit quotient,
// and three for the square and saturation.
// The whole pipeline advances together; it holds only while a finished item waits at the
// output. A zero Biot number or any overflow gives all ones with the saturated flag set.
module drying_onset_time_solver_top #(
	parameter int SEARCH_STEPS = dots_pkg::SEARCH_STEPS_DEF,
	parameter int FRAC_BITS    = dots_pkg::FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // biot_number [23:0], temp_rise_fraction [39:24]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // dry_time [31:0]
	output logic [0:0]  m_tuser   // saturated [0]
);
	import dots_pkg::*;

	localparam int XW = 32 + SEARCH_STEPS;

	logic          en;
	logic          srch_v;
	logic [30:0]   srch_xm;
	logic [23:0]   srch_bi;
	logic          rcp_v;
	logic [XW-1:0] rcp_x;
	logic [23:0]   rcp_bi;
	logic          quo_v;
	logic [47:0]   quo_r;
	logic          quo_ovf;
	logic          sq_sat;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	dots_search #(.SEARCH_STEPS(SEARCH_STEPS)) u_search (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(s_tvalid && s_tready),
		.in_theta(s_tdata[39:24]), .in_biot(s_tdata[23:0]),
		.out_valid(srch_v), .out_xm(srch_xm), .out_biot(srch_bi)
	);

	dots_recip #(.SEARCH_STEPS(SEARCH_STEPS), .QW(XW)) u_recip (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(srch_v), .in_xm(srch_xm), .in_biot(srch_bi),
		.out_valid(rcp_v), .out_x(rcp_x), .out_biot(rcp_bi)
	);

	dots_quot #(.FRAC_BITS(FRAC_BITS), .XW(XW)) u_quot (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(rcp_v), .in_x(rcp_x), .in_biot(rcp_bi),
		.out_valid(quo_v), .out_r(quo_r), .out_ovf(quo_ovf)
	);

	dots_square #(.FRAC_BITS(FRAC_BITS)) u_square (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(quo_v), .in_r(quo_r), .in_ovf(quo_ovf),
		.out_valid(m_tvalid), .out_time(m_tdata), .out_sat(sq_sat)
	);

	assign m_tuser = sq_sat;

`include "drying_onset_time_solver_top_assert.svh"
	`DOTS_ASSERT_IMP(a_sat_all_ones, m_tvalid && m_tuser[0], m_tdata == 32'hFFFF_FFFF)
	`DOTS_ASSERT_IMP(a_ready_when_taken, m_tready, s_tready)
	`DOTS_ASSERT_NXT(a_stall_freezes, !s_tready, $stable(srch_v) && $stable(quo_v))
endmodule

[tb/tb_top.sv]
// Self-checking testbench for the drying onset time solver pipeline.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 4 * dots_pkg::SEARCH_STEPS_DEF + 85;
	localparam int LIMIT = 200000;
	localparam logic [63:0] ONE31 = 64'd1 << 31;
	localparam logic [63:0] SAT = 64'hFFFF_FFFF;

	typedef struct packed {
		logic [31:0] dry_time;
		logic        saturated;
	} onset_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [0:0]  m_tuser;

	logic [39:0] pending_items[$];
	onset_t      expected_onsets[$];
	int          errors = 0;
	int          cycles = 0;
	bit          calm = 1'b0;
	bit          loaded = 1'b0;

	drying_onset_time_solver_top dut (.*);

	always #6 clk = ~clk;

	function automatic bit below_root(logic [63:0] h, logic [15:0] theta);
		logic [63:0] h2, h3, g, lhs, rhs;
		h2 = (h * h) >> 31;
		h3 = (h2 * h) >> 31;
		g = ((64'(dots_pkg::QB) * h) >> 31) + h3 - ((64'(dots_pkg::QC) * h2) >> 31);
		lhs = (g * 64'(dots_pkg::QA)) >> 31;
		rhs = (64'd65536 - 64'(theta)) << 15;
		return lhs < rhs;
	endfunction

	function automatic onset_t onset_time(logic [23:0] biot, logic [15:0] theta);
		logic [63:0] lo, hi, xm, x, k;
		logic [127:0] num, r, sq;
		onset_t o;
		lo = 0;
		hi = ONE31;
		xm = 0;
		for (int n = 0; n < dots_pkg::SEARCH_STEPS_DEF; n++) begin
			xm = (lo + hi) >> 1;
			if (below_root(xm, theta)) lo = xm; else hi = xm;
		end
		o.dry_time = '1;
		o.saturated = 1'b1;
		if (biot == 0 || xm == 0) return o;
		x = ((ONE31 - xm) << 32) / xm;
		k = 64'(biot) * 64'(dots_pkg::QP2);
		num = 128'(x) << 40;
		r = num / 128'(k);
		if (r >> 48 != 0) return o;
		sq = r * r;
		sq = sq >> 48;
		if (sq > 128'(SAT)) return o;
		o.dry_time = sq[31:0];
		o.saturated = 1'b0;
		return o;
	endfunction

	task automatic report(string what, onset_t got, onset_t want);
		$display("mismatch %s: got %h/%b want %h/%b", what, got.dry_time, got.saturated,
			want.dry_time, want.saturated);
		errors++;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				expected_onsets.push_back(onset_time(s_tdata[23:0], s_tdata[39:24]));
			end
			if ((!s_tvalid || s_tready) && pending_items.size() > 0 &&
					(calm || $urandom_range(99) >= 6)) begin
				s_tvalid <= 1'b1;
				s_tdata <= pending_items.pop_front();
			end else if (!s_tvalid || s_tready) begin
				s_tvalid <= 1'b0;
			end
			m_tready <= calm || $urandom_range(99) >= 6;
		end
	end

	always @(posedge clk) begin
		onset_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.dry_time = m_tdata;
			got.saturated = m_tuser[0];
			if (expected_onsets.size() == 0) begin
				report("unexpected", got, got);
			end else begin
				want = expected_onsets.pop_front();
				if (got.dry_time !== want.dry_time) report("dry_time", got, want);
				if (got.saturated !== want.saturated) report("saturated", got, want);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		calm <= (cycles % 400) >= 250;
		if (cycles > LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	task automatic add_item(logic [23:0] biot, logic [15:0] theta);
		pending_items.push_back({theta, biot});
	endtask

	initial begin
		logic [23:0] b;
		add_item(24'd0, 16'd0);
		add_item(24'd0, 16'hFFFF);
		add_item(24'hFFFFFF, 16'd0);
		add_item(24'hFFFFFF, 16'hFFFF);
		add_item(24'd1, 16'd0);
		add_item(24'd1, 16'hFFFF);
		add_item(24'h010000, 16'h8000);
		add_item(24'h000100, 16'h4000);
		add_item(24'h000001, 16'h0001);
		add_item(24'h800000, 16'h8000);
		add_item(24'h555555, 16'hAAAA);
		add_item(24'hAAAAAA, 16'h5555);
		add_item(24'h010000, 16'hFFFF);
		add_item(24'h010000, 16'd0);
		add_item(24'h004000, 16'h1000);
		for (int i = 0; i < 500; i++) begin
			case ($urandom_range(3))
				0: b = 24'($urandom);
				1: b = 24'($urandom_range(32'h40000, 32'h1000));
				2: b = 24'($urandom_range(255));
				default: b = 24'($urandom_range(32'h800000, 32'h10000));
			endcase
			add_item(b, 16'($urandom));
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_items.size() == 0);
		@(posedge clk);
		while (s_tvalid) @(posedge clk);
		while (expected_onsets.size() > 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (errors == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end
endmodule

[filelist.f]
+incdir+src
src/dots_pkg.sv
src/dots_search.sv
src/dots_recip.sv
src/dots_quot.sv
src/dots_square.sv
src/drying_onset_time_solver_top.sv
tb/tb_top.sv
